/* src/assert_macros.svh */
// Assertion helpers shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LPF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("framer assertion failed");

// Check that a condition never shows on a rising clock edge outside reset.
`define LPF_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("framer forbidden condition seen");

`endif

/* src/lpf_pkg.sv */
package lpf_pkg;

   localparam int unsigned REM_W     = 10;
   localparam int unsigned STEP_W    = 5;
   localparam int unsigned HDR_BYTES = 18;
   localparam int unsigned CRC_BYTES = 2;
   localparam int unsigned IDX_W     = 3;

   typedef logic [STEP_W-1:0] step_type;

   // Byte positions inside one item's run of beats.
   localparam step_type STEP_FIRST    = 5'd0;
   localparam step_type HDR_MAGIC_HI  = 5'd1;
   localparam step_type HDR_VERSION   = 5'd2;
   localparam step_type HDR_DEVICE    = 5'd3;
   localparam step_type HDR_STAMP     = 5'd11;
   localparam step_type HDR_TYPE      = 5'd15;
   localparam step_type HDR_LENGTH    = 5'd16;
   localparam step_type STEP_HDR_LAST = 5'd17;
   localparam step_type STEP_CRC_LO   = 5'd18;
   localparam step_type STEP_CRC_HI   = 5'd19;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   typedef enum logic [IDX_W-1:0] {
      CSR_ENABLE,
      CSR_ALWAYS_SEND,
      CSR_MAGIC_WORD,
      CSR_PROTOCOL_VERSION,
      CSR_DEVICE_IDENTITY
   } csr_index_type;

   typedef struct packed {
      logic        enable;
      logic        always_send;
      logic [15:0] magic_word;
      logic [7:0]  protocol_version;
      logic [63:0] device_identity;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        end_of_run;
      logic        packet_done;
      logic        dropped;
      logic [31:0] sent_total;
      logic [31:0] dropped_total;
   } beat_type;

endpackage

/* src/lpf_csr.sv */
module lpf_csr
   import lpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [63:0]      csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:           cfg_in.enable           = csr_wdata[0];
            CSR_ALWAYS_SEND:      cfg_in.always_send      = csr_wdata[0];
            CSR_MAGIC_WORD:       cfg_in.magic_word       = csr_wdata[15:0];
            CSR_PROTOCOL_VERSION: cfg_in.protocol_version = csr_wdata[7:0];
            CSR_DEVICE_IDENTITY:  cfg_in.device_identity  = csr_wdata;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/lpf_seq.sv */
`include "assert_macros.svh"

module lpf_seq
   import lpf_pkg::*;
#(
   parameter int unsigned MAX_PACKET = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_log_type,
   input  logic [15:0] req_payload_length,
   input  logic [31:0] req_timestamp_ms,
   input  logic        req_link_attached,
   input  logic        req_listener_present,
   input  logic [7:0]  req_payload_byte,
   output logic        beat_valid,
   input  logic        beat_ready,
   output beat_type    beat
);

   localparam logic [16:0] LEN_LIMIT = 17'(MAX_PACKET - HDR_BYTES - CRC_BYTES);

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != '0) c = (c << 1) ^ CRC_POLY;
         else                     c = c << 1;
      end
      return c;
   endfunction

   // held item
   logic        hold_valid_ff;
   logic        cmd_ff;
   logic [7:0]  type_ff;
   logic [15:0] len_ff;
   logic [31:0] ts_ff;
   logic        link_ff;
   logic        listener_ff;
   logic [7:0]  pbyte_ff;

   // framer state
   step_type         step_ff, step_in;
   logic             open_ff, open_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [15:0]      crc_ff, crc_in;
   logic [31:0]      sent_ff, sent_in;
   logic [31:0]      drop_ff, drop_in;

   logic       emit;
   logic       last;
   logic       advance;
   logic       refuse;
   logic [7:0] hdr_byte;
   logic [2:0] dev_sel;
   logic [1:0] ts_sel;

   assign dev_sel = 3'(step_ff - HDR_DEVICE);
   assign ts_sel  = 2'(step_ff - HDR_STAMP);
   assign refuse  = !link_ff || (!cfg.always_send && !listener_ff)
                    || ({1'b0, len_ff} > LEN_LIMIT);

   always_comb begin
      case (step_ff) inside
         STEP_FIRST:                 hdr_byte = cfg.magic_word[7:0];
         HDR_MAGIC_HI:               hdr_byte = cfg.magic_word[15:8];
         HDR_VERSION:                hdr_byte = cfg.protocol_version;
         [HDR_DEVICE:HDR_STAMP-1]:   hdr_byte = cfg.device_identity[dev_sel*8 +: 8];
         [HDR_STAMP:HDR_TYPE-1]:     hdr_byte = ts_ff[ts_sel*8 +: 8];
         HDR_TYPE:                   hdr_byte = type_ff;
         HDR_LENGTH:                 hdr_byte = len_ff[7:0];
         STEP_HDR_LAST:              hdr_byte = len_ff[15:8];
         default:                    hdr_byte = '0;
      endcase
   end

   always_comb begin
      emit    = 1'b0;
      last    = 1'b1;
      step_in = STEP_FIRST;
      open_in = open_ff;
      rem_in  = rem_ff;
      crc_in  = crc_ff;
      sent_in = sent_ff;
      drop_in = drop_ff;
      beat    = '0;

      if (step_ff == STEP_CRC_LO) begin
         emit          = 1'b1;
         last          = 1'b0;
         step_in       = STEP_CRC_HI;
         sent_in       = sent_ff + 32'd1;
         open_in       = 1'b0;
         beat.out_byte = crc_ff[7:0];
      end else if (step_ff == STEP_CRC_HI) begin
         emit             = 1'b1;
         crc_in           = CRC_INIT;
         beat.out_byte    = crc_ff[15:8];
         beat.packet_done = 1'b1;
      end else if (cmd_ff == CMD_START) begin
         if (!cfg.enable) begin
            emit = 1'b0;
         end else if (step_ff == STEP_FIRST && refuse) begin
            emit         = 1'b1;
            open_in      = 1'b0;
            rem_in       = '0;
            crc_in       = CRC_INIT;
            drop_in      = drop_ff + 32'd1;
            beat.dropped = 1'b1;
         end else begin
            emit          = 1'b1;
            beat.out_byte = hdr_byte;
            // a start abandons whatever packet was open
            crc_in = crc_feed((step_ff == STEP_FIRST) ? CRC_INIT : crc_ff, hdr_byte);
            if (step_ff == STEP_FIRST) begin
               open_in = 1'b0;
               rem_in  = '0;
            end
            if (step_ff == STEP_HDR_LAST) begin
               if (len_ff == '0) begin
                  last    = 1'b0;
                  step_in = STEP_CRC_LO;
               end else begin
                  open_in = 1'b1;
                  rem_in  = len_ff[REM_W-1:0];
               end
            end else begin
               last    = 1'b0;
               step_in = step_ff + 5'd1;
            end
         end
      end else if (open_ff) begin
         emit          = 1'b1;
         beat.out_byte = pbyte_ff;
         crc_in        = crc_feed(crc_ff, pbyte_ff);
         rem_in        = rem_ff - 10'd1;
         if (rem_in == '0) begin
            last    = 1'b0;
            step_in = STEP_CRC_LO;
         end
      end

      beat.end_of_run    = last;
      beat.sent_total    = sent_in;
      beat.dropped_total = drop_in;
   end

   assign advance    = hold_valid_ff && (!emit || beat_ready);
   assign beat_valid = hold_valid_ff && emit;
   assign req_ready  = !hold_valid_ff || (advance && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         step_ff       <= STEP_FIRST;
         open_ff       <= 1'b0;
         rem_ff        <= '0;
         crc_ff        <= CRC_INIT;
         sent_ff       <= '0;
         drop_ff       <= '0;
      end else begin
         if (req_ready) begin
            hold_valid_ff <= req_valid;
         end
         if (advance) begin
            step_ff <= last ? STEP_FIRST : step_in;
            open_ff <= open_in;
            rem_ff  <= rem_in;
            crc_ff  <= crc_in;
            sent_ff <= sent_in;
            drop_ff <= drop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff      <= req_command;
         type_ff     <= req_log_type;
         len_ff      <= req_payload_length;
         ts_ff       <= req_timestamp_ms;
         link_ff     <= req_link_attached;
         listener_ff <= req_listener_present;
         pbyte_ff    <= req_payload_byte;
      end
   end

   `LPF_ASSERT(a_done_ends_run, clock, reset, (beat_valid && beat.packet_done) |-> beat.end_of_run)
   `LPF_ASSERT(a_drop_beat_form, clock, reset, (beat_valid && beat.dropped) |-> (beat.end_of_run && beat.out_byte == 8'h00))
   `LPF_ASSERT(a_crc_hi_follows, clock, reset, (advance && step_ff == STEP_CRC_LO) |=> (hold_valid_ff && step_ff == STEP_CRC_HI))
   `LPF_NEVER(a_idle_mid_item, clock, reset, !hold_valid_ff && step_ff != STEP_FIRST)

endmodule

/* src/lpf_out.sv */
`include "assert_macros.svh"

module lpf_out
   import lpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        beat_valid,
   output logic        beat_ready,
   input  beat_type    beat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_run,
   output logic        rsp_packet_done,
   output logic        rsp_dropped,
   output logic [31:0] rsp_sent_total,
   output logic [31:0] rsp_dropped_total
);

   beat_type   ent_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;
   beat_type   head;

   assign beat_ready = !count_ff[1];
   assign push       = beat_valid && beat_ready;
   assign rsp_valid  = count_ff != 2'd0;
   assign pop        = rsp_valid && rsp_ready;
   assign head       = ent_ff[rd_ff];

   assign rsp_out_byte      = head.out_byte;
   assign rsp_end_of_run    = head.end_of_run;
   assign rsp_packet_done   = head.packet_done;
   assign rsp_dropped       = head.dropped;
   assign rsp_sent_total    = head.sent_total;
   assign rsp_dropped_total = head.dropped_total;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= beat;
      end
   end

   `LPF_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `LPF_NEVER(a_push_when_full, clock, reset, push && count_ff == 2'd2)
   `LPF_ASSERT(a_pop_drains, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))

endmodule

/* src/log_packet_framer_crc16_unit.sv */
// Log packet framer: a start beat on req opens a packet and produces the 18-byte
// little-endian header (magic, version, device id, timestamp, type, length) on rsp,
// one byte per beat; each payload beat then yields its byte, and after the last one
// the CRC16 (init 0xFFFF, poly 0x1021, over header and payload) follows low byte
// first, with packet_done set on the high byte. A refused start gives a single beat
// with dropped set. Each input item yields one result beat per byte it causes: a
// payload byte one (three when it closes the packet), an accepted start 18 (20 with
// an empty payload), a refused start one, while a start with enable clear or a
// payload beat with no packet open yields none. Payload beats stream back to back
// at one per cycle while the output queue has room. A two-entry output queue holds
// finished beats, so rsp stalls do not reach req until both entries are full. Write
// csr registers only while idle; csr_ready is always high.
module log_packet_framer_crc16_unit
   import lpf_pkg::*;
#(
   parameter int unsigned MAX_PACKET = 1024
)
(
   input  logic             clock,
   input  logic             reset,
   // configuration writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [63:0]      csr_wdata,
   // input items
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [7:0]       req_log_type,
   input  logic [15:0]      req_payload_length,
   input  logic [31:0]      req_timestamp_ms,
   input  logic             req_link_attached,
   input  logic             req_listener_present,
   input  logic [7:0]       req_payload_byte,
   // result beats
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_run,
   output logic             rsp_packet_done,
   output logic             rsp_dropped,
   output logic [31:0]      rsp_sent_total,
   output logic [31:0]      rsp_dropped_total
);

   cfg_type  cfg;
   beat_type beat;
   logic     beat_valid;
   logic     beat_ready;

   // configuration registers
   lpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // hold the item, step through its bytes, advance the CRC and counters
   lpf_seq #(
      .MAX_PACKET (MAX_PACKET)
   ) u_seq (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_log_type         (req_log_type),
      .req_payload_length   (req_payload_length),
      .req_timestamp_ms     (req_timestamp_ms),
      .req_link_attached    (req_link_attached),
      .req_listener_present (req_listener_present),
      .req_payload_byte     (req_payload_byte),
      .beat_valid           (beat_valid),
      .beat_ready           (beat_ready),
      .beat                 (beat)
   );

   // register finished beats toward rsp
   lpf_out u_out (
      .clock             (clock),
      .reset             (reset),
      .beat_valid        (beat_valid),
      .beat_ready        (beat_ready),
      .beat              (beat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_dropped       (rsp_dropped),
      .rsp_sent_total    (rsp_sent_total),
      .rsp_dropped_total (rsp_dropped_total)
   );

endmodule
